FILE: rtl/sbt_pkg.sv
// subpiece bitmap tracker: shared opcodes, status codes, config indexes and port widths
// no dependencies; used by subpiece_receive_bitmap_tracker_unit
package sbt_pkg;

    localparam int OP_W       = 3;
    localparam int BLK_PORT_W = 8;
    localparam int SUB_PORT_W = 11;
    localparam int RUN_W      = 20;
    localparam int BYTES_W    = 30;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    typedef logic [OP_W-1:0]      opcode_t;
    typedef logic [1:0]           status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    typedef logic [BYTES_W-1:0]   bytes_t;

    localparam opcode_t OP_ADD    = 3'd0;
    localparam opcode_t OP_QUERY  = 3'd1;
    localparam opcode_t OP_FIND   = 3'd2;
    localparam opcode_t OP_REMOVE = 3'd3;
    localparam opcode_t OP_INIT   = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_DUP   = 2'd2;

    localparam cfg_index_t CFG_LAST_BLOCK  = 3'd0;
    localparam cfg_index_t CFG_SPB         = 3'd1;
    localparam cfg_index_t CFG_LAST_BLK_SP = 3'd2;
    localparam cfg_index_t CFG_LAST_SP_B   = 3'd3;
    localparam cfg_index_t CFG_START_FULL  = 3'd4;

    localparam bytes_t BYTES_MAX = '1;

endpackage

FILE: rtl/subpiece_receive_bitmap_tracker_unit.sv
// subpiece receive bitmap tracker: presence bitmap in one piece-word memory, find/remove scans
// depends on sbt_pkg
//
// channel  | handshake             | contents
// ---------+-----------------------+--------------------------------------------------
// in       | in_valid / in_stall   | opcode, block_sel, subpiece_sel
// out      | out_valid / out_stall | status, present, block_full, found, next_block,
//          |                       | next_subpiece, run_length, downloaded_bytes
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one word at a time: query reads at most one piece word; add sets its bit, then checks the
// block's piece words for completion, or writes the whole row on an unwritten block; find
// and remove scan piece words in turn; init full writes every piece word of blocks
// 0..last_block, one per cycle. reset clears valid bits, byte count, config, no memory pass.
// results sit in an output register, so the next word is taken while a result is stalled.
module subpiece_receive_bitmap_tracker_unit #(
    parameter int MAX_BLOCKS              = 256,
    parameter int MAX_SUBPIECES_PER_BLOCK = 2048,
    parameter int SUBPIECES_PER_PIECE     = 128,
    parameter int SUBPIECE_BYTES          = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  sbt_pkg::opcode_t                    opcode,
    input  logic [sbt_pkg::BLK_PORT_W-1:0]      block_sel,
    input  logic [sbt_pkg::SUB_PORT_W-1:0]      subpiece_sel,
    output logic                                out_valid,
    input  logic                                out_stall,
    output sbt_pkg::status_t                    status,
    output logic                                present,
    output logic                                block_full,
    output logic                                found,
    output logic [sbt_pkg::BLK_PORT_W-1:0]      next_block,
    output logic [sbt_pkg::SUB_PORT_W-1:0]      next_subpiece,
    output logic [sbt_pkg::RUN_W-1:0]           run_length,
    output sbt_pkg::bytes_t                     downloaded_bytes,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  sbt_pkg::cfg_index_t                 cfg_index,
    input  logic [sbt_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SPP    = SUBPIECES_PER_PIECE;
    localparam int SH     = $clog2(SPP);
    localparam int BLK_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SUB_W  = $clog2(MAX_SUBPIECES_PER_BLOCK);
    localparam int CNT_W  = $clog2(MAX_SUBPIECES_PER_BLOCK + 1);
    localparam int WPB    = MAX_SUBPIECES_PER_BLOCK / SPP;
    localparam int WRD_W  = (WPB > 1) ? $clog2(WPB) : 1;
    localparam int ADDR_W = BLK_W + WRD_W;
    localparam int DEPTH  = MAX_BLOCKS * (1 << WRD_W);
    localparam int SB_W   = $clog2(SUBPIECE_BYTES + 1);
    localparam int ACC_W  = BLK_W + CNT_W + 1 + SB_W;
    localparam int PC_W   = SH + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_TEV   = 4'd2;
    localparam logic [3:0] S_AFILL = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_EV    = 4'd5;
    localparam logic [3:0] S_RMB   = 4'd6;
    localparam logic [3:0] S_RMC   = 4'd7;
    localparam logic [3:0] S_IMUL  = 4'd8;
    localparam logic [3:0] S_IBYT  = 4'd9;
    localparam logic [3:0] S_IFILL = 4'd10;
    localparam logic [3:0] S_RUN   = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    // bits of a piece word that lie below the block size n
    function automatic logic [SPP-1:0] word_mask(input logic [31:0] n, input logic [31:0] w);
        logic [SPP-1:0] m;
        logic signed [32:0] lim;
        lim = $signed({1'b0, n}) - $signed({1'b0, w << SH});
        for (int k = 0; k < SPP; k++) begin
            m[k] = (lim > k);
        end
        return m;
    endfunction

    function automatic logic [SPP-1:0] low_mask(input logic [SH-1:0] b);
        logic [SPP-1:0] m;
        for (int k = 0; k < SPP; k++) begin
            m[k] = (k < int'(b));
        end
        return m;
    endfunction

    function automatic logic [PC_W-1:0] popcnt(input logic [SPP-1:0] d);
        logic [PC_W-1:0] c;
        c = '0;
        for (int k = 0; k < SPP; k++) begin
            c = c + PC_W'(d[k]);
        end
        return c;
    endfunction

    function automatic logic [SH-1:0] first_zero(input logic [SPP-1:0] d);
        logic [SH-1:0] idx;
        idx = '0;
        for (int k = SPP - 1; k >= 0; k--) begin
            if (!d[k]) idx = SH'(k);
        end
        return idx;
    endfunction

    // configuration
    logic [7:0]  last_block_reg;
    logic [11:0] spb_reg;
    logic [11:0] lbs_reg;
    logic [10:0] lsb_reg;
    logic        start_full_reg;

    // control and result registers
    logic [3:0]             state_reg, state_next;
    sbt_pkg::opcode_t       op_reg, op_next;
    logic [7:0]             bi_reg, bi_next;
    logic [10:0]            si_reg, si_next;
    logic [BLK_W-1:0]       cb_reg, cb_next;
    logic [WRD_W-1:0]       cw_reg, cw_next;
    logic                   first_reg, first_next;
    sbt_pkg::status_t       st_reg, st_next;
    logic                   pr_reg, pr_next;
    logic                   bf_reg, bf_next;
    logic                   fd_reg, fd_next;
    logic [BLK_W-1:0]       eb_reg, eb_next;
    logic [SUB_W-1:0]       es_reg, es_next;
    logic [sbt_pkg::RUN_W-1:0] run_reg, run_next;
    sbt_pkg::bytes_t        bc_reg, bc_next;
    logic [CNT_W-1:0]       held_reg, held_next;
    logic                   hl_reg, hl_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [MAX_BLOCKS-1:0]  rowv_reg, rowv_next;

    // output register
    logic                   ov_reg, ov_next;
    sbt_pkg::status_t       o_st_reg, o_st_next;
    logic                   o_pr_reg, o_pr_next;
    logic                   o_bf_reg, o_bf_next;
    logic                   o_fd_reg, o_fd_next;
    logic [7:0]             o_nb_reg, o_nb_next;
    logic [10:0]            o_ns_reg, o_ns_next;
    logic [sbt_pkg::RUN_W-1:0] o_run_reg, o_run_next;
    sbt_pkg::bytes_t        o_bc_reg, o_bc_next;

    // piece word memory
    logic [SPP-1:0]    mem [DEPTH];
    logic [SPP-1:0]    rd_data_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_wa, mem_ra;
    logic [SPP-1:0]    mem_wd;

    // effective configuration
    logic [31:0]      t_last, t_spb, t_lbs, t_lsb;
    logic [BLK_W-1:0] eff_last;
    logic [CNT_W-1:0] eff_spb, eff_lbs;
    logic [SB_W-1:0]  eff_lsb;
    logic [31:0]      lfw32, lfb32;

    // decoded request
    logic [31:0]      tb32, ts32, nsz32, tw32;
    logic             blk_ok, sub_ok;
    logic [BLK_W-1:0] blk_i;
    logic [SUB_W-1:0] sub_i;
    logic [WRD_W-1:0] tw_i;
    logic [SH-1:0]    sbit_i;
    logic [SPP-1:0]   onehot_i;
    logic [31:0]      sb32, bsum32;

    // scan position
    logic [31:0]      ncur32, lw32;
    logic             cw_is_last, cb_is_last;
    logic [SPP-1:0]   cmask, fd_word;
    logic [31:0]      es32;
    logic [BLK_W+CNT_W-1:0] rprod;
    logic [31:0]      run32;
    logic [63:0]      tot64, hb64, bc64, dif64;

    always_comb
    begin
        t_last = ({24'd0, last_block_reg} > 32'(MAX_BLOCKS - 1)) ? 32'(MAX_BLOCKS - 1)
                                                                 : {24'd0, last_block_reg};
        t_spb = {20'd0, spb_reg};
        if (t_spb < 32'd1) t_spb = 32'd1;
        if (t_spb > 32'(MAX_SUBPIECES_PER_BLOCK)) t_spb = 32'(MAX_SUBPIECES_PER_BLOCK);
        t_lbs = {20'd0, lbs_reg};
        if (t_lbs < 32'd1) t_lbs = 32'd1;
        if (t_lbs > t_spb) t_lbs = t_spb;
        t_lsb = {21'd0, lsb_reg};
        if (t_lsb < 32'd1) t_lsb = 32'd1;
        if (t_lsb > 32'(SUBPIECE_BYTES)) t_lsb = 32'(SUBPIECE_BYTES);
    end

    assign eff_last = t_last[BLK_W-1:0];
    assign eff_spb  = t_spb[CNT_W-1:0];
    assign eff_lbs  = t_lbs[CNT_W-1:0];
    assign eff_lsb  = t_lsb[SB_W-1:0];
    assign lfw32    = (t_lbs - 32'd1) >> SH;
    assign lfb32    = (t_lbs - 32'd1) & 32'(SPP - 1);

    assign tb32     = {24'd0, bi_reg};
    assign ts32     = {21'd0, si_reg};
    assign blk_ok   = (tb32 <= t_last);
    assign nsz32    = (tb32 == t_last) ? t_lbs : t_spb;
    assign sub_ok   = blk_ok && (ts32 < nsz32);
    assign blk_i    = tb32[BLK_W-1:0];
    assign sub_i    = ts32[SUB_W-1:0];
    assign tw32     = ts32 >> SH;
    assign tw_i     = tw32[WRD_W-1:0];
    assign sbit_i   = ts32[SH-1:0];
    assign onehot_i = SPP'(1) << sbit_i;
    // the short final subpiece counts at its own size
    assign sb32     = (tb32 == t_last && ts32 == t_lbs - 32'd1) ? t_lsb
                                                                 : 32'(SUBPIECE_BYTES);
    assign bsum32   = {2'b00, bc_reg} + sb32;

    assign cb_is_last = (cb_reg == eff_last);
    assign ncur32     = cb_is_last ? t_lbs : t_spb;
    assign lw32       = (ncur32 - 32'd1) >> SH;
    assign cw_is_last = (32'(cw_reg) == lw32);
    assign cmask      = word_mask(ncur32, 32'(cw_reg));
    assign fd_word    = rd_data_reg | ~cmask | (first_reg ? low_mask(sbit_i) : '0);
    assign es32       = (32'(cw_reg) << SH) | 32'(first_zero(fd_word));

    assign rprod  = (BLK_W+CNT_W)'(eb_reg - blk_i) * (BLK_W+CNT_W)'(eff_spb);
    assign run32  = 32'(rprod) + 32'(es_reg) - 32'(sub_i) + 32'd1;
    assign tot64  = 64'(acc_reg) * 64'(SUBPIECE_BYTES) - 64'(SUBPIECE_BYTES) + 64'(eff_lsb);
    assign hb64   = 64'(acc_reg) - (hl_reg ? 64'(SUBPIECE_BYTES) - 64'(eff_lsb) : 64'd0);
    assign bc64   = 64'(bc_reg);
    assign dif64  = bc64 - hb64;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        bi_next    = bi_reg;
        si_next    = si_reg;
        cb_next    = cb_reg;
        cw_next    = cw_reg;
        first_next = first_reg;
        st_next    = st_reg;
        pr_next    = pr_reg;
        bf_next    = bf_reg;
        fd_next    = fd_reg;
        eb_next    = eb_reg;
        es_next    = es_reg;
        run_next   = run_reg;
        bc_next    = bc_reg;
        held_next  = held_reg;
        hl_next    = hl_reg;
        acc_next   = acc_reg;
        rowv_next  = rowv_reg;
        ov_next    = ov_reg && out_stall;
        o_st_next  = o_st_reg;
        o_pr_next  = o_pr_reg;
        o_bf_next  = o_bf_reg;
        o_fd_next  = o_fd_reg;
        o_nb_next  = o_nb_reg;
        o_ns_next  = o_ns_reg;
        o_run_next = o_run_reg;
        o_bc_next  = o_bc_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_wa     = {blk_i, tw_i};
        mem_ra     = {cb_reg, cw_reg};
        mem_wd     = rd_data_reg | onehot_i;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    bi_next    = block_sel;
                    si_next    = subpiece_sel;
                    st_next    = sbt_pkg::ST_OK;
                    pr_next    = 1'b0;
                    bf_next    = 1'b0;
                    fd_next    = 1'b0;
                    eb_next    = '0;
                    es_next    = '0;
                    run_next   = '0;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = S_DONE;
                cb_next    = blk_i;
                cw_next    = '0;
                first_next = 1'b0;
                held_next  = '0;
                hl_next    = 1'b0;
                mem_ra     = {blk_i, tw_i};
                unique case (op_reg)
                    sbt_pkg::OP_ADD:
                    begin
                        if (!sub_ok)
                        begin
                            st_next = sbt_pkg::ST_RANGE;
                        end
                        else if (!rowv_reg[blk_i])
                        begin
                            // first touch of this block: write the whole row
                            bc_next    = (bsum32 > 32'(sbt_pkg::BYTES_MAX)) ? sbt_pkg::BYTES_MAX
                                                                            : bsum32[29:0];
                            bf_next    = (nsz32 == 32'd1);
                            state_next = S_AFILL;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = S_TEV;
                        end
                    end
                    sbt_pkg::OP_QUERY:
                    begin
                        if (!sub_ok)
                        begin
                            st_next = sbt_pkg::ST_RANGE;
                        end
                        else if (rowv_reg[blk_i])
                        begin
                            mem_re     = 1'b1;
                            state_next = S_TEV;
                        end
                    end
                    sbt_pkg::OP_FIND:
                    begin
                        eb_next = eff_last;
                        es_next = SUB_W'(t_lbs - 32'd1);
                        if (!sub_ok)
                        begin
                            st_next = sbt_pkg::ST_RANGE;
                        end
                        else
                        begin
                            cw_next    = tw_i;
                            first_next = 1'b1;
                            state_next = S_RD;
                        end
                    end
                    sbt_pkg::OP_REMOVE:
                    begin
                        if (!blk_ok)
                            st_next = sbt_pkg::ST_RANGE;
                        else if (rowv_reg[blk_i])
                            state_next = S_RD;
                        else
                            state_next = S_RMB;
                    end
                    sbt_pkg::OP_INIT:
                    begin
                        rowv_next = '0;
                        bc_next   = '0;
                        if (start_full_reg)
                            state_next = S_IMUL;
                    end
                    default:
                    begin
                        st_next = sbt_pkg::ST_RANGE;
                    end
                endcase
            end
            S_TEV:
            begin
                state_next = S_DONE;
                if (op_reg == sbt_pkg::OP_QUERY)
                begin
                    pr_next = rd_data_reg[sbit_i];
                end
                else if (rd_data_reg[sbit_i])
                begin
                    st_next = sbt_pkg::ST_DUP;
                end
                else
                begin
                    mem_we     = 1'b1;
                    bc_next    = (bsum32 > 32'(sbt_pkg::BYTES_MAX)) ? sbt_pkg::BYTES_MAX
                                                                    : bsum32[29:0];
                    cw_next    = '0;
                    state_next = S_RD;
                end
            end
            S_AFILL:
            begin
                mem_we = 1'b1;
                mem_wa = {blk_i, cw_reg};
                mem_wd = (cw_reg == tw_i) ? onehot_i : '0;
                if (cw_reg == WRD_W'(WPB - 1))
                begin
                    rowv_next[blk_i] = 1'b1;
                    state_next       = S_DONE;
                end
                else
                begin
                    cw_next = cw_reg + WRD_W'(1);
                end
            end
            S_RD:
            begin
                // a find on a block never written stops at its first position
                if (op_reg == sbt_pkg::OP_FIND && !rowv_reg[cb_reg])
                begin
                    fd_next    = 1'b1;
                    eb_next    = cb_reg;
                    es_next    = first_reg ? sub_i : '0;
                    state_next = S_RUN;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_EV;
                end
            end
            S_EV:
            begin
                state_next = S_RD;
                unique case (op_reg)
                    sbt_pkg::OP_ADD:
                    begin
                        if ((rd_data_reg | ~cmask) != '1)
                        begin
                            state_next = S_DONE;
                        end
                        else if (cw_is_last)
                        begin
                            bf_next    = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cw_next = cw_reg + WRD_W'(1);
                        end
                    end
                    sbt_pkg::OP_REMOVE:
                    begin
                        held_next = held_reg + CNT_W'(popcnt(rd_data_reg & cmask));
                        if (cb_is_last && 32'(cw_reg) == lfw32)
                            hl_next = rd_data_reg[lfb32[SH-1:0]];
                        if (cw_is_last)
                            state_next = S_RMB;
                        else
                            cw_next = cw_reg + WRD_W'(1);
                    end
                    default:
                    begin
                        first_next = 1'b0;
                        if (fd_word != '1)
                        begin
                            fd_next    = 1'b1;
                            eb_next    = cb_reg;
                            es_next    = es32[SUB_W-1:0];
                            state_next = S_RUN;
                        end
                        else if (cw_is_last)
                        begin
                            if (cb_is_last)
                            begin
                                state_next = S_RUN;
                            end
                            else
                            begin
                                cb_next = cb_reg + BLK_W'(1);
                                cw_next = '0;
                            end
                        end
                        else
                        begin
                            cw_next = cw_reg + WRD_W'(1);
                        end
                    end
                endcase
            end
            S_RMB:
            begin
                acc_next   = ACC_W'(held_reg) * ACC_W'(SUBPIECE_BYTES);
                state_next = S_RMC;
            end
            S_RMC:
            begin
                bc_next          = (hb64 >= bc64) ? '0 : dif64[29:0];
                rowv_next[blk_i] = 1'b0;
                state_next       = S_DONE;
            end
            S_IMUL:
            begin
                acc_next   = ACC_W'(eff_last) * ACC_W'(eff_spb) + ACC_W'(eff_lbs);
                state_next = S_IBYT;
            end
            S_IBYT:
            begin
                bc_next    = (tot64 > 64'(sbt_pkg::BYTES_MAX)) ? sbt_pkg::BYTES_MAX
                                                               : tot64[29:0];
                cb_next    = '0;
                cw_next    = '0;
                state_next = S_IFILL;
            end
            S_IFILL:
            begin
                mem_we = 1'b1;
                mem_wa = {cb_reg, cw_reg};
                mem_wd = cmask;
                if (cw_reg == WRD_W'(WPB - 1))
                begin
                    rowv_next[cb_reg] = 1'b1;
                    cw_next           = '0;
                    if (cb_is_last)
                        state_next = S_DONE;
                    else
                        cb_next = cb_reg + BLK_W'(1);
                end
                else
                begin
                    cw_next = cw_reg + WRD_W'(1);
                end
            end
            S_RUN:
            begin
                run_next   = run32[sbt_pkg::RUN_W-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    o_st_next  = st_reg;
                    o_pr_next  = pr_reg;
                    o_bf_next  = bf_reg;
                    o_fd_next  = fd_reg;
                    o_nb_next  = 8'(eb_reg);
                    o_ns_next  = 11'(es_reg);
                    o_run_next = run_reg;
                    o_bc_next  = bc_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rowv_reg       <= '0;
            bc_reg         <= '0;
            ov_reg         <= 1'b0;
            last_block_reg <= 8'd0;
            spb_reg        <= 12'd2048;
            lbs_reg        <= 12'd1;
            lsb_reg        <= 11'd1024;
            start_full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rowv_reg  <= rowv_next;
            bc_reg    <= bc_next;
            ov_reg    <= ov_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    sbt_pkg::CFG_LAST_BLOCK:  last_block_reg <= cfg_data[7:0];
                    sbt_pkg::CFG_SPB:         spb_reg        <= cfg_data;
                    sbt_pkg::CFG_LAST_BLK_SP: lbs_reg        <= cfg_data;
                    sbt_pkg::CFG_LAST_SP_B:   lsb_reg        <= cfg_data[10:0];
                    sbt_pkg::CFG_START_FULL:  start_full_reg <= cfg_data[0];
                    default:                  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        bi_reg    <= bi_next;
        si_reg    <= si_next;
        cb_reg    <= cb_next;
        cw_reg    <= cw_next;
        first_reg <= first_next;
        st_reg    <= st_next;
        pr_reg    <= pr_next;
        bf_reg    <= bf_next;
        fd_reg    <= fd_next;
        eb_reg    <= eb_next;
        es_reg    <= es_next;
        run_reg   <= run_next;
        held_reg  <= held_next;
        hl_reg    <= hl_next;
        acc_reg   <= acc_next;
        o_st_reg  <= o_st_next;
        o_pr_reg  <= o_pr_next;
        o_bf_reg  <= o_bf_next;
        o_fd_reg  <= o_fd_next;
        o_nb_reg  <= o_nb_next;
        o_ns_reg  <= o_ns_next;
        o_run_reg <= o_run_next;
        o_bc_reg  <= o_bc_next;
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign cfg_ready        = 1'b1;
    assign out_valid        = ov_reg;
    assign status           = o_st_reg;
    assign present          = o_pr_reg;
    assign block_full       = o_bf_reg;
    assign found            = o_fd_reg;
    assign next_block       = o_nb_reg;
    assign next_subpiece    = o_ns_reg;
    assign run_length       = o_run_reg;
    assign downloaded_bytes = o_bc_reg;

    a_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg != S_IDLE)
        else $error("memory write while idle");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re && mem_wa == mem_ra))
        else $error("read and write to the same piece word in one cycle");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == sbt_pkg::ST_OK)
        else $error("found reported with error status");

    a_dup_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == sbt_pkg::ST_DUP |-> !block_full && !found && !present)
        else $error("duplicate add reported extra flags");

endmodule
